/* hdl/bqro_pkg.sv */
// Shared types and constants for the broadcast queue with per-reader offsets.
// Holds status and function codes, the command set and the flag bundle.
// No dependencies.
package bqro_pkg;

  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [2:0] FN_SUB    = 3'd0;
  localparam logic [2:0] FN_UNSUB  = 3'd1;
  localparam logic [2:0] FN_ADD    = 3'd2;
  localparam logic [2:0] FN_GET    = 3'd3;
  localparam logic [2:0] FN_AVAIL  = 3'd4;
  localparam logic [2:0] FN_REMOVE = 3'd5;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_SUB    = 3'd1;
  localparam logic [2:0] ST_FULL       = 3'd2;
  localparam logic [2:0] ST_NOTHING    = 3'd3;
  localparam logic [2:0] ST_DROPPED    = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd5;
  localparam logic [2:0] ST_TABLE_FULL = 3'd6;

  typedef enum logic [4:0] {
    C_NONE,
    C_LOAD,
    C_SUB,
    C_ADD,
    C_SET_STATUS,
    C_TAG_STEP,
    C_UNSUB,
    C_AVAIL,
    C_GET_ISSUE,
    C_GET_TAKE,
    C_MIN_START,
    C_MIN_STEP,
    C_RETIRE,
    C_MSG_ISSUE,
    C_MSG_NEXT,
    C_MARK,
    C_COPY_ISSUE,
    C_COPY_WRITE,
    C_REMOVE_DONE,
    C_OUTPUT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [2:0] st;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       tag_end;
    logic       tag_hit;
    logic       off_empty;
    logic       msg_end;
    logic       msg_hit;
    logic       copy_end;
  } flags_t;

endpackage

/* hdl/bqro_dp.sv */
// Datapath: message store, subscriber table, counters, capacity register
// and the output register. Executes one command per cycle.
// Depends on bqro_pkg.
module bqro_dp #(
  parameter int MSG_DEPTH       = 16,
  parameter int MAX_SUBSCRIBERS = 16,
  parameter int DATA_WIDTH      = 32,
  parameter int ID_WIDTH        = 16,
  localparam int CW             = $clog2(MSG_DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bqro_pkg::cmd_t            cmd,
  output bqro_pkg::flags_t          flags,
  input  logic [2:0]                func,
  input  logic [ID_WIDTH-1:0]       subscriber_id,
  input  logic [DATA_WIDTH-1:0]     message_data,
  input  logic                      cfg_we,
  input  logic [bqro_pkg::CAP_W-1:0] cfg_wdata,
  output logic [bqro_pkg::CAP_W-1:0] capacity,
  output logic [2:0]                status,
  output logic [DATA_WIDTH-1:0]     read_data,
  output logic [CW-1:0]             available_count
);

  localparam int AW  = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
  localparam int SW  = $clog2(MAX_SUBSCRIBERS + 1);
  localparam int SIW = (MAX_SUBSCRIBERS > 1) ? $clog2(MAX_SUBSCRIBERS) : 1;
  localparam int IXW = (SW > CW) ? SW : CW;
  localparam int EW  = (CW > bqro_pkg::CAP_W) ? CW : bqro_pkg::CAP_W;

  logic [DATA_WIDTH-1:0] store [MSG_DEPTH];
  logic [DATA_WIDTH-1:0] rd_q;
  logic [ID_WIDTH-1:0]   tags [MAX_SUBSCRIBERS];
  logic [CW-1:0]         offs [MAX_SUBSCRIBERS];
  logic [CW-1:0]         count;
  logic [AW-1:0]         oldest;
  logic [SW-1:0]         scount;
  logic [2:0]            func_q;
  logic [ID_WIDTH-1:0]   tag_q;
  logic [DATA_WIDTH-1:0] data_q;
  logic [IXW-1:0]        idx;
  logic [CW-1:0]         fidx;
  logic [CW-1:0]         minv;
  logic [2:0]            status_q;
  logic [DATA_WIDTH-1:0] rdata_q;
  logic [CW-1:0]         avail_q;

  logic [SIW-1:0]        sidx;
  logic [CW-1:0]         cur_off;
  logic                  add_full;
  logic                  sub_full;
  logic [AW-1:0]         raddr;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic                  we;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [CW-1:0] k);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(k);
    if (s >= (CW+1)'(MSG_DEPTH)) begin
      s = s - (CW+1)'(MSG_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign sidx     = idx[SIW-1:0];
  assign cur_off  = offs[sidx];
  assign sub_full = scount >= SW'(MAX_SUBSCRIBERS);
  assign add_full = (EW'(count) >= EW'(capacity)) || (count >= CW'(MSG_DEPTH));

  assign flags.func      = func_q;
  assign flags.tag_end   = idx >= IXW'(scount);
  assign flags.tag_hit   = tags[sidx] == tag_q;
  assign flags.off_empty = cur_off >= count;
  assign flags.msg_end   = idx >= IXW'(count);
  assign flags.msg_hit   = rd_q == data_q;
  assign flags.copy_end  = ({1'b0, idx} + (IXW+1)'(1)) >= (IXW+1)'(count);

  always_comb begin
    case (cmd.op)
      bqro_pkg::C_GET_ISSUE:  raddr = slot(oldest, cur_off);
      bqro_pkg::C_COPY_ISSUE: raddr = slot(oldest, idx[CW-1:0] + CW'(1));
      default:                raddr = slot(oldest, idx[CW-1:0]);
    endcase
    if (cmd.op == bqro_pkg::C_COPY_WRITE) begin
      we    = 1'b1;
      waddr = slot(oldest, idx[CW-1:0]);
      wdata = rd_q;
    end else begin
      we    = (cmd.op == bqro_pkg::C_ADD) && (scount != '0) && !add_full;
      waddr = slot(oldest, count);
      wdata = data_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == bqro_pkg::C_GET_ISSUE || cmd.op == bqro_pkg::C_MSG_ISSUE ||
        cmd.op == bqro_pkg::C_COPY_ISSUE) begin
      rd_q <= store[raddr];
    end
    if (we) begin
      store[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      oldest   <= '0;
      scount   <= '0;
      capacity <= bqro_pkg::CAP_RESET;
    end else begin
      if (cfg_we && count == '0) begin
        capacity <= cfg_wdata;
      end
      case (cmd.op)
        bqro_pkg::C_SUB: begin
          if (!sub_full) scount <= scount + SW'(1);
        end
        bqro_pkg::C_ADD: begin
          if (scount != '0 && !add_full) count <= count + CW'(1);
        end
        bqro_pkg::C_UNSUB: begin
          scount <= scount - SW'(1);
        end
        bqro_pkg::C_RETIRE: begin
          count  <= count - minv;
          oldest <= slot(oldest, minv);
        end
        bqro_pkg::C_REMOVE_DONE: begin
          count <= count - CW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      bqro_pkg::C_LOAD: begin
        func_q   <= func;
        tag_q    <= subscriber_id;
        data_q   <= message_data;
        idx      <= '0;
        status_q <= bqro_pkg::ST_OK;
        rdata_q  <= '0;
        avail_q  <= '0;
      end
      bqro_pkg::C_SUB: begin
        if (sub_full) begin
          status_q <= bqro_pkg::ST_TABLE_FULL;
        end else begin
          tags[scount[SIW-1:0]] <= tag_q;
          offs[scount[SIW-1:0]] <= count;
        end
      end
      bqro_pkg::C_ADD: begin
        if (scount == '0) status_q <= bqro_pkg::ST_DROPPED;
        else if (add_full) status_q <= bqro_pkg::ST_FULL;
      end
      bqro_pkg::C_SET_STATUS: status_q <= cmd.st;
      bqro_pkg::C_TAG_STEP, bqro_pkg::C_MSG_NEXT, bqro_pkg::C_COPY_WRITE: begin
        idx <= idx + IXW'(1);
      end
      bqro_pkg::C_UNSUB: begin
        // close the gap left by the removed entry
        for (int j = 0; j < MAX_SUBSCRIBERS - 1; j++) begin
          if (SIW'(j) >= sidx) begin
            tags[j] <= tags[j+1];
            offs[j] <= offs[j+1];
          end
        end
      end
      bqro_pkg::C_AVAIL: begin
        avail_q <= (cur_off >= count) ? '0 : count - cur_off;
      end
      bqro_pkg::C_GET_TAKE: begin
        rdata_q    <= rd_q;
        offs[sidx] <= cur_off + CW'(1);
      end
      bqro_pkg::C_MIN_START: begin
        idx  <= '0;
        minv <= count;
      end
      bqro_pkg::C_MIN_STEP: begin
        if (cur_off < minv) minv <= cur_off;
        idx <= idx + IXW'(1);
      end
      bqro_pkg::C_RETIRE: begin
        for (int j = 0; j < MAX_SUBSCRIBERS; j++) begin
          offs[j] <= offs[j] - minv;
        end
      end
      bqro_pkg::C_MARK: fidx <= idx[CW-1:0];
      bqro_pkg::C_REMOVE_DONE: begin
        for (int j = 0; j < MAX_SUBSCRIBERS; j++) begin
          if (offs[j] > fidx) offs[j] <= offs[j] - CW'(1);
        end
      end
      bqro_pkg::C_OUTPUT: begin
        status          <= status_q;
        read_data       <= rdata_q;
        available_count <= avail_q;
      end
      default: ;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MSG_DEPTH)) else $error("message count above depth");
  a_sub_bound: assert property (@(posedge clk) disable iff (rst)
    scount <= SW'(MAX_SUBSCRIBERS)) else $error("subscriber count above table size");
  a_oldest_bound: assert property (@(posedge clk) disable iff (rst)
    32'(oldest) < MSG_DEPTH) else $error("oldest slot out of range");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.op == bqro_pkg::C_OUTPUT && status_q != bqro_pkg::ST_OK |=>
      read_data == '0 && available_count == '0)
    else $error("failed request carries data");

endmodule

/* hdl/bqro_ctrl.sv */
// Controller: sequences each request through search, read, retire and
// compaction steps and owns the output valid flag.
// Depends on bqro_pkg.
module bqro_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  bqro_pkg::flags_t flags,
  output bqro_pkg::cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_SRCH, S_GCHK, S_GTAKE, S_MIN0, S_MINS,
    S_MRD, S_MCMP, S_CRD, S_CWR, S_FIN
  } state_t;

  state_t state, state_next;

  assign in_stall = state != S_IDLE;

  always_comb begin
    cmd.op     = bqro_pkg::C_NONE;
    cmd.st     = bqro_pkg::ST_OK;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = bqro_pkg::C_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (flags.func)
          bqro_pkg::FN_SUB: begin
            cmd.op     = bqro_pkg::C_SUB;
            state_next = S_FIN;
          end
          bqro_pkg::FN_ADD: begin
            cmd.op     = bqro_pkg::C_ADD;
            state_next = S_FIN;
          end
          bqro_pkg::FN_UNSUB, bqro_pkg::FN_GET, bqro_pkg::FN_AVAIL: state_next = S_SRCH;
          bqro_pkg::FN_REMOVE: state_next = S_MRD;
          default: state_next = S_FIN;
        endcase
      end
      S_SRCH: begin
        if (flags.tag_end) begin
          cmd.op     = bqro_pkg::C_SET_STATUS;
          cmd.st     = bqro_pkg::ST_NOT_SUB;
          state_next = S_FIN;
        end else if (flags.tag_hit) begin
          case (flags.func)
            bqro_pkg::FN_UNSUB: begin
              cmd.op     = bqro_pkg::C_UNSUB;
              state_next = S_MIN0;
            end
            bqro_pkg::FN_GET: state_next = S_GCHK;
            default: begin
              cmd.op     = bqro_pkg::C_AVAIL;
              state_next = S_FIN;
            end
          endcase
        end else begin
          cmd.op = bqro_pkg::C_TAG_STEP;
        end
      end
      S_GCHK: begin
        if (flags.off_empty) begin
          cmd.op     = bqro_pkg::C_SET_STATUS;
          cmd.st     = bqro_pkg::ST_NOTHING;
          state_next = S_FIN;
        end else begin
          cmd.op     = bqro_pkg::C_GET_ISSUE;
          state_next = S_GTAKE;
        end
      end
      S_GTAKE: begin
        cmd.op     = bqro_pkg::C_GET_TAKE;
        state_next = S_MIN0;
      end
      S_MIN0: begin
        cmd.op     = bqro_pkg::C_MIN_START;
        state_next = S_MINS;
      end
      S_MINS: begin
        // walk offsets for the minimum, then retire that many messages
        if (flags.tag_end) begin
          cmd.op     = bqro_pkg::C_RETIRE;
          state_next = S_FIN;
        end else begin
          cmd.op = bqro_pkg::C_MIN_STEP;
        end
      end
      S_MRD: begin
        if (flags.msg_end) begin
          cmd.op     = bqro_pkg::C_SET_STATUS;
          cmd.st     = bqro_pkg::ST_NOT_FOUND;
          state_next = S_FIN;
        end else begin
          cmd.op     = bqro_pkg::C_MSG_ISSUE;
          state_next = S_MCMP;
        end
      end
      S_MCMP: begin
        if (flags.msg_hit) begin
          cmd.op     = bqro_pkg::C_MARK;
          state_next = S_CRD;
        end else begin
          cmd.op     = bqro_pkg::C_MSG_NEXT;
          state_next = S_MRD;
        end
      end
      S_CRD: begin
        if (flags.copy_end) begin
          cmd.op     = bqro_pkg::C_REMOVE_DONE;
          state_next = S_FIN;
        end else begin
          cmd.op     = bqro_pkg::C_COPY_ISSUE;
          state_next = S_CWR;
        end
      end
      S_CWR: begin
        cmd.op     = bqro_pkg::C_COPY_WRITE;
        state_next = S_CRD;
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid || !out_stall) begin
          cmd.op     = bqro_pkg::C_OUTPUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == bqro_pkg::C_OUTPUT) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

/* hdl/broadcast_queue_with_reader_offsets_top.sv */
// Broadcast queue top: one request in, one result out, capacity over APB.
// Subscribe and add finish straight from dispatch; get and unsubscribe walk the subscriber
// table, and remove walks and compacts the stored words through one store port.
// Throughput: one request at a time; a new one is taken while a result waits.
// Reset (synchronous, rst high) clears counters and state; capacity returns to 16.
// Depends on bqro_pkg, bqro_ctrl, bqro_dp.
module broadcast_queue_with_reader_offsets_top #(
  parameter int MSG_DEPTH       = 16,
  parameter int MAX_SUBSCRIBERS = 16,
  parameter int DATA_WIDTH      = 32,
  parameter int ID_WIDTH        = 16,
  localparam int CW             = $clog2(MSG_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            func,
  input  logic [ID_WIDTH-1:0]   subscriber_id,
  input  logic [DATA_WIDTH-1:0] message_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            status,
  output logic [DATA_WIDTH-1:0] read_data,
  output logic [CW-1:0]         available_count,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  bqro_pkg::cmd_t              cmd;
  bqro_pkg::flags_t            flags;
  logic                        cfg_we;
  logic [bqro_pkg::CAP_W-1:0]  capacity;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : 32'(capacity);

  bqro_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .flags     (flags),
    .cmd       (cmd)
  );

  bqro_dp #(
    .MSG_DEPTH       (MSG_DEPTH),
    .MAX_SUBSCRIBERS (MAX_SUBSCRIBERS),
    .DATA_WIDTH      (DATA_WIDTH),
    .ID_WIDTH        (ID_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .flags           (flags),
    .func            (func),
    .subscriber_id   (subscriber_id),
    .message_data    (message_data),
    .cfg_we          (cfg_we),
    .cfg_wdata       (pwdata[bqro_pkg::CAP_W-1:0]),
    .capacity        (capacity),
    .status          (status),
    .read_data       (read_data),
    .available_count (available_count)
  );

endmodule
